### hdl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Command and status codes, default sizes and the control word that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_ID_WIDTH = 8;

  // Port widths of the command word and the result word.
  localparam int CMD_BITS    = 3;
  localparam int NODE_BITS   = 8;
  localparam int STATUS_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_FIND       = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE     = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  // Shift and load controls, already qualified by full and empty checks.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic remove;
  } bdq_ctl_t;

endpackage

### hdl/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one identifier, compares it against the key and moves it toward
// the front or the back together with its neighbors.
// ----------------------------------------------------------------------------
module bdq_cell #(
  parameter int ID_WIDTH = bdq_pkg::DEF_ID_WIDTH
) (
  input  logic                clk,
  input  bdq_pkg::bdq_ctl_t   ctl,
  input  logic [ID_WIDTH-1:0] key,
  input  logic                occupied,
  input  logic                tail,
  input  logic [ID_WIDTH-1:0] from_front,
  input  logic [ID_WIDTH-1:0] from_back,
  input  logic                hit_in,
  output logic                hit_out,
  output logic [ID_WIDTH-1:0] data
);

  // The hit chain is set from the first matching cell onward, so every
  // cell at or behind the first match closes the gap on a remove.
  assign hit_out = hit_in | (occupied && (data == key));

  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      data <= from_front;
    end else if (ctl.pop_front || (ctl.remove && hit_out)) begin
      data <= from_back;
    end else if (ctl.push_back && tail) begin
      data <= key;
    end
  end

endmodule

### hdl/bounded_deque_with_find_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with find and remove
// Ordered store of identifiers held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (command, node_id) is taken at a rising edge where start
//   is high and busy is low. busy stays low: every command finishes in the
//   cycle it is taken, so a new word may be given on every cycle.
//   In the cycle after a command is taken, done is high for exactly one cycle
//   with result_id, status and count. The receiver cannot stall; results are
//   not held. Throughput is one command per cycle. The whole command
//   (compare in every cell, the first-match chain through the row and the
//   shift of all cells) is worked out combinationally into the registers;
//   the match chain across the row of cells sets the clock period.
//   Pushes at the front and pops at the front shift the whole row; pushes
//   and pops at the back only touch the tail. A remove shifts every cell
//   from the first match onward toward the front.
//   Synchronous reset empties the deque and clears done; cell contents are
//   not cleared, as only occupied cells are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_find_remove #(
  parameter int CAPACITY = bdq_pkg::DEF_CAPACITY,
  parameter int ID_WIDTH = bdq_pkg::DEF_ID_WIDTH,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bdq_pkg::CMD_BITS-1:0]    command,
  input  logic [bdq_pkg::NODE_BITS-1:0]   node_id,
  output logic                            done,
  output logic [bdq_pkg::NODE_BITS-1:0]   result_id,
  output logic [bdq_pkg::STATUS_BITS-1:0] status,
  output logic [CNT_W-1:0]                count
);

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                found;
  logic [ID_WIDTH-1:0] key;
  logic [ID_WIDTH-1:0] back_data;
  logic [ID_WIDTH-1:0] res_word;
  logic [bdq_pkg::STATUS_BITS-1:0] status_next;
  bdq_pkg::bdq_ctl_t   ctl;

  logic [ID_WIDTH-1:0] cell_data [CAPACITY];
  logic [ID_WIDTH-1:0] back_pick [CAPACITY];
  logic [CAPACITY:0]   hit;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign key    = ID_WIDTH'(node_id);
  assign full   = (cnt == CNT_W'(CAPACITY));
  assign empty  = (cnt == '0);
  assign found  = hit[CAPACITY];
  assign hit[0] = 1'b0;

  always_comb begin
    ctl            = '0;
    ctl.push_front = accept && (command == bdq_pkg::CMD_PUSH_FRONT) && !full;
    ctl.push_back  = accept && (command == bdq_pkg::CMD_PUSH_BACK) && !full;
    ctl.pop_front  = accept && (command == bdq_pkg::CMD_POP_FRONT) && !empty;
    ctl.remove     = accept && (command == bdq_pkg::CMD_REMOVE);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_WIDTH-1:0] from_front;
    logic [ID_WIDTH-1:0] from_back;

    if (i == 0) begin : g_head
      assign from_front = key;
    end else begin : g_body
      assign from_front = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign from_back = '0;
    end else begin : g_mid
      assign from_back = cell_data[i+1];
    end

    bdq_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key),
      .occupied  (cnt > CNT_W'(i)),
      .tail      (cnt == CNT_W'(i)),
      .from_front(from_front),
      .from_back (from_back),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .data      (cell_data[i])
    );

    // The last occupied cell drives the pop-back word; all others give zero.
    if (i == 0) begin : g_pick0
      assign back_pick[i] = (cnt == CNT_W'(i + 1)) ? cell_data[i] : '0;
    end else begin : g_pickn
      assign back_pick[i] = back_pick[i-1] |
                            ((cnt == CNT_W'(i + 1)) ? cell_data[i] : '0);
    end
  end

  assign back_data = back_pick[CAPACITY-1];

  always_comb begin
    res_word    = key;
    status_next = bdq_pkg::ST_OK;
    cnt_next    = cnt;
    unique case (command)
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_next = bdq_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          res_word    = '0;
          status_next = bdq_pkg::ST_EMPTY;
        end else begin
          res_word = (command == bdq_pkg::CMD_POP_FRONT) ? cell_data[0] : back_data;
          cnt_next = cnt - 1'b1;
        end
      end
      bdq_pkg::CMD_FIND: begin
        if (!found) begin
          status_next = bdq_pkg::ST_NOT_FOUND;
        end
      end
      bdq_pkg::CMD_REMOVE: begin
        if (!found) begin
          status_next = bdq_pkg::ST_NOT_FOUND;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_id <= bdq_pkg::NODE_BITS'(res_word);
      status    <= status_next;
    end
  end

  assign count = cnt;

  // The occupancy never exceeds the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  // A result word appears only for a command taken on the cycle before.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("result without a command");

  // An empty flag is only given while nothing is stored.
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (done && (status == bdq_pkg::ST_EMPTY)) |-> (count == '0))
    else $error("empty status with stored words");

  // A full flag is only given when every cell is occupied.
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (done && (status == bdq_pkg::ST_FULL)) |-> (count == CNT_W'(CAPACITY)))
    else $error("full status with free cells");

  // A successful remove takes exactly one word out.
  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(command) == bdq_pkg::CMD_REMOVE) && (status == bdq_pkg::ST_OK))
      |-> (count == CNT_W'($past(cnt) - 1'b1)))
    else $error("remove did not shorten the deque by one");

endmodule
